FILE: hdl/bpsc_pkg.sv
package bpsc_pkg;

  localparam int unsigned ByteWidth = 8;
  localparam int unsigned PosWidth  = 3;
  localparam int unsigned HeadCount = 3;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [PosWidth-1:0] SyncPos = PosWidth'(HeadCount);
  localparam logic [PosWidth-1:0] PosSat  = PosWidth'(HeadCount + 1);

  localparam logic [ByteWidth-1:0] PatternOddBit = ByteWidth'(1);

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_RECOVER_MODE = 2'd0,
    REG_SEED_VALUE   = 2'd1,
    REG_START_COUNT  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 last_byte;
  } in_beat_t;

  typedef struct packed {
    logic                 pattern_ok;
    logic                 sync_found;
    logic [ByteWidth-1:0] found_seed;
    logic [ByteWidth-1:0] found_start;
  } out_beat_t;

  function automatic logic [ByteWidth-1:0] expected_byte(
    input logic [ByteWidth-1:0] n,
    input logic [ByteWidth-1:0] seed
  );
    return ((n & PatternOddBit) != '0) ? seed : n;
  endfunction

endpackage

FILE: hdl/bpsc_in.sv
module bpsc_in (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  bpsc_pkg::in_beat_t byte_beat,
  input  logic              item_take,
  output logic              item_valid,
  output bpsc_pkg::in_beat_t item
);
  import bpsc_pkg::*;

  logic accept;

  assign byte_stall = item_valid && !item_take;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= byte_beat;
    end
  end

endmodule

FILE: hdl/bpsc_out.sv
module bpsc_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_load,
  input  bpsc_pkg::out_beat_t res,
  output logic               res_free,
  output logic               verdict_valid,
  input  logic               verdict_stall,
  output bpsc_pkg::out_beat_t verdict_beat
);
  import bpsc_pkg::*;

  assign res_free = !verdict_valid || !verdict_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (res_load) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      verdict_beat <= res;
    end
  end

endmodule

FILE: hdl/bpsc_core.sv
module bpsc_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [bpsc_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  logic [bpsc_pkg::ByteWidth-1:0]         cfg_data,
  input  logic                                   item_valid,
  input  bpsc_pkg::in_beat_t                     item,
  input  logic                                   res_free,
  output logic                                   item_take,
  output logic                                   res_load,
  output bpsc_pkg::out_beat_t                    res
);
  import bpsc_pkg::*;

  logic                 cfg_mode;
  logic [ByteWidth-1:0] cfg_seed;
  logic [ByteWidth-1:0] cfg_start;

  logic [ByteWidth-1:0] head [HeadCount];
  logic [PosWidth-1:0]  pos;
  logic [PosWidth-1:0]  pos_next;
  logic [ByteWidth-1:0] count_now;
  logic [ByteWidth-1:0] count_now_next;
  logic [ByteWidth-1:0] seed_in_use;
  logic [ByteWidth-1:0] seed_in_use_next;
  logic [ByteWidth-1:0] start_in_use;
  logic [ByteWidth-1:0] start_in_use_next;
  logic                 mode_in_use;
  logic                 mode_in_use_next;
  logic                 mismatch_seen;
  logic                 mismatch_seen_next;
  logic                 sync_failed;
  logic                 sync_failed_next;

  logic                 first;
  logic                 load_fixed;
  logic [ByteWidth-1:0] seed_cur;
  logic [ByteWidth-1:0] start_cur;
  logic [ByteWidth-1:0] count_cur;
  logic                 mism_cur;
  logic                 fail_cur;
  logic                 byte_mism;
  logic                 rec_a;
  logic                 rec_b;
  logic [ByteWidth-1:0] rec_seed;
  logic [ByteWidth-1:0] rec_n;
  logic                 rec_mism;
  logic                 synced;

  assign item_take = item_valid && (!item.last_byte || res_free);
  assign res_load  = item_take && item.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode  <= 1'b0;
      cfg_seed  <= '0;
      cfg_start <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RECOVER_MODE: cfg_mode  <= cfg_data[0];
        REG_SEED_VALUE:   cfg_seed  <= cfg_data;
        REG_START_COUNT:  cfg_start <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    first      = (pos == '0);
    load_fixed = first && !cfg_mode;
    mode_in_use_next = first ? cfg_mode : mode_in_use;
    seed_cur   = load_fixed ? cfg_seed : seed_in_use;
    start_cur  = load_fixed ? cfg_start : start_in_use;
    count_cur  = load_fixed ? cfg_start : count_now;
    mism_cur   = first ? 1'b0 : mismatch_seen;
    fail_cur   = first ? 1'b0 : sync_failed;

    byte_mism = (item.data_byte != expected_byte(count_cur, seed_cur));

    rec_a = (head[2] == head[0]) &&
            (item.data_byte == ByteWidth'(head[1] - ByteWidth'(2)));
    rec_b = (item.data_byte == head[1]) &&
            (head[2] == ByteWidth'(head[0] - ByteWidth'(2)));
    rec_seed = rec_a ? head[0] : head[1];
    rec_n    = rec_a ? ByteWidth'(head[1] + ByteWidth'(1)) : head[0];
    rec_mism = (head[0] != expected_byte(rec_n, rec_seed)) ||
               (head[1] != expected_byte(ByteWidth'(rec_n - ByteWidth'(1)), rec_seed)) ||
               (head[2] != expected_byte(ByteWidth'(rec_n - ByteWidth'(2)), rec_seed)) ||
               (item.data_byte !=
                expected_byte(ByteWidth'(rec_n - ByteWidth'(3)), rec_seed));

    seed_in_use_next   = seed_cur;
    start_in_use_next  = start_cur;
    count_now_next     = count_cur;
    mismatch_seen_next = mism_cur;
    sync_failed_next   = fail_cur;

    priority if (!mode_in_use_next) begin
      mismatch_seen_next = mism_cur || byte_mism;
      count_now_next     = ByteWidth'(count_cur - ByteWidth'(1));
    end else if (pos < SyncPos) begin
      // head byte captured in the register block
    end else if (pos == SyncPos) begin
      if (rec_a || rec_b) begin
        seed_in_use_next   = rec_seed;
        start_in_use_next  = rec_n;
        count_now_next     = ByteWidth'(rec_n - ByteWidth'(4));
        mismatch_seen_next = mism_cur || rec_mism;
      end else begin
        sync_failed_next = 1'b1;
      end
    end else if (!fail_cur) begin
      mismatch_seen_next = mism_cur || byte_mism;
      count_now_next     = ByteWidth'(count_cur - ByteWidth'(1));
    end

    if (item.last_byte) begin
      pos_next = '0;
    end else if (pos < PosSat) begin
      pos_next = PosWidth'(pos + PosWidth'(1));
    end else begin
      pos_next = pos;
    end

    synced = !mode_in_use_next || ((pos >= SyncPos) && !sync_failed_next);
    res.pattern_ok  = synced && !mismatch_seen_next;
    res.sync_found  = synced;
    res.found_seed  = synced ? seed_in_use_next : '0;
    res.found_start = synced ? start_in_use_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      count_now     <= '0;
      seed_in_use   <= '0;
      start_in_use  <= '0;
      mode_in_use   <= 1'b0;
      mismatch_seen <= 1'b0;
      sync_failed   <= 1'b0;
    end else if (item_take) begin
      pos           <= pos_next;
      count_now     <= count_now_next;
      seed_in_use   <= seed_in_use_next;
      start_in_use  <= start_in_use_next;
      mode_in_use   <= mode_in_use_next;
      mismatch_seen <= mismatch_seen_next;
      sync_failed   <= sync_failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && mode_in_use_next && (pos < SyncPos)) begin
      head[pos[1:0]] <= item.data_byte;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= PosSat)
    else $error("byte position beyond saturation");

  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (pos == '0))
    else $error("byte position not cleared after last beat");

  a_fail_zeroes: assert property (@(posedge clk) disable iff (rst)
    (res_load && !res.sync_found) |->
      (!res.pattern_ok && (res.found_seed == '0) && (res.found_start == '0)))
    else $error("sync failure verdict carries data");

  a_fixed_synced: assert property (@(posedge clk) disable iff (rst)
    (res_load && !mode_in_use_next) |-> res.sync_found)
    else $error("fixed mode verdict without sync");

  a_short_packet: assert property (@(posedge clk) disable iff (rst)
    (res_load && mode_in_use_next && (pos < SyncPos)) |-> !res.sync_found)
    else $error("short recovery packet reported sync");

endmodule

FILE: hdl/byte_pattern_sync_checker.sv
// Byte pattern checker with fixed or recovered seed and start counter.
// A byte is registered in bpsc_in and then processed by bpsc_core; its verdict
//   (last byte only) is registered in bpsc_out before it is valid.
// Throughput: one byte per cycle; a waiting verdict stalls only a last byte.
// Reset (rst, synchronous): clears registers, packet state and output valid.
module byte_pattern_sync_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  bpsc_pkg::in_beat_t                 byte_beat,
  output logic                               verdict_valid,
  input  logic                               verdict_stall,
  output bpsc_pkg::out_beat_t                verdict_beat,
  input  logic                               cfg_write,
  input  logic [bpsc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [bpsc_pkg::ByteWidth-1:0]     cfg_data
);
  import bpsc_pkg::*;

  logic      item_valid;
  in_beat_t  item;
  logic      item_take;
  logic      res_load;
  out_beat_t res;
  logic      res_free;

  bpsc_in u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_beat  (byte_beat),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  bpsc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .res_free   (res_free),
    .item_take  (item_take),
    .res_load   (res_load),
    .res        (res)
  );

  bpsc_out u_out (
    .clk           (clk),
    .rst           (rst),
    .res_load      (res_load),
    .res           (res),
    .res_free      (res_free),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict_beat  (verdict_beat)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bpsc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomPhases = 10;
  localparam int BytesPerPhase = 110;

  class verdict_scoreboard;
    bit                   cfg_recover;
    logic [ByteWidth-1:0] cfg_seed;
    logic [ByteWidth-1:0] cfg_start;

    logic [ByteWidth-1:0] head [HeadCount];
    logic [PosWidth-1:0]  pos;
    logic [ByteWidth-1:0] count;
    logic [ByteWidth-1:0] seed;
    logic [ByteWidth-1:0] start;
    bit                   recovering;
    bit                   mismatch;
    bit                   lost_sync;

    out_beat_t verdicts_due[$];
    int        errors;
    int        verdicts_checked;
    int        bytes_seen;

    function new();
      cfg_recover = 0;
      cfg_seed = '0;
      cfg_start = '0;
      pos = '0;
      count = '0;
      seed = '0;
      start = '0;
      recovering = 0;
      mismatch = 0;
      lost_sync = 0;
      errors = 0;
      verdicts_checked = 0;
      bytes_seen = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [ByteWidth-1:0] value);
      case (idx)
        REG_RECOVER_MODE: cfg_recover = value[0];
        REG_SEED_VALUE:   cfg_seed = value;
        REG_START_COUNT:  cfg_start = value;
        default: ;
      endcase
    endfunction

    // compare against the pattern at the current count, then count down
    function void step_count(logic [ByteWidth-1:0] b);
      if (b != (count[0] ? seed : count)) mismatch = 1;
      count = count - 8'd1;
    endfunction

    function void note_byte(in_beat_t beat);
      logic [ByteWidth-1:0] b;
      logic [ByteWidth-1:0] s;
      logic [ByteWidth-1:0] n;
      bit                   synced;
      out_beat_t            due;
      b = beat.data_byte;
      bytes_seen++;
      if (pos == '0) begin
        recovering = cfg_recover;
        mismatch = 0;
        lost_sync = 0;
        if (!recovering) begin
          seed = cfg_seed;
          start = cfg_start;
          count = cfg_start;
        end
      end
      if (!recovering) begin
        step_count(b);
      end else if (pos < SyncPos) begin
        head[pos[1:0]] = b;
      end else if (pos == SyncPos) begin
        // odd start: seed, n-1, seed, n-3; even start: n, seed, n-2, seed
        s = head[0];
        n = 8'(head[1] + 8'd1);
        if (head[2] != s || b != 8'(head[1] - 8'd2)) begin
          s = head[1];
          n = head[0];
          if (b != s || head[2] != 8'(head[0] - 8'd2)) lost_sync = 1;
        end
        if (!lost_sync) begin
          seed = s;
          start = n;
          count = n;
          step_count(head[0]);
          step_count(head[1]);
          step_count(head[2]);
          step_count(b);
        end
      end else if (!lost_sync) begin
        step_count(b);
      end
      if (pos < PosSat) pos = pos + 1'b1;
      if (beat.last_byte) begin
        synced = !recovering || (pos >= PosSat && !lost_sync);
        due.pattern_ok = synced && !mismatch;
        due.sync_found = synced;
        due.found_seed = synced ? seed : '0;
        due.found_start = synced ? start : '0;
        verdicts_due.push_back(due);
        pos = '0;
      end
    endfunction

    function void report(string field, logic [ByteWidth-1:0] want, logic [ByteWidth-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(out_beat_t got);
      out_beat_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict with none due, expected nothing, actual %p", $time, got);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      verdicts_checked++;
      report("pattern_ok", ByteWidth'(want.pattern_ok), ByteWidth'(got.pattern_ok));
      report("sync_found", ByteWidth'(want.sync_found), ByteWidth'(got.sync_found));
      report("found_seed", want.found_seed, got.found_seed);
      report("found_start", want.found_start, got.found_start);
    endfunction

    function int outstanding();
      return verdicts_due.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     byte_valid = 1'b0;
  logic                     byte_stall;
  in_beat_t                 byte_beat = '0;
  logic                     verdict_valid;
  logic                     verdict_stall = 1'b0;
  out_beat_t                verdict_beat;
  logic                     cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [ByteWidth-1:0]     cfg_data = '0;

  verdict_scoreboard sb = new();
  bit quiet = 0;
  int settings_used = 0;
  int bytes_sent = 0;
  int cycle_count;

  byte_pattern_sync_checker u_top (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_beat     (byte_beat),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict_beat  (verdict_beat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.write_reg(cfg_reg_e'(cfg_index), cfg_data);
      if (byte_valid && !byte_stall) sb.note_byte(byte_beat);
      if (verdict_valid && !verdict_stall) sb.check_verdict(verdict_beat);
    end
  end

  always @(posedge clk) begin
    verdict_stall <= !rst && !quiet && ($urandom_range(99) < 27);
  end

  task automatic send_byte(logic [ByteWidth-1:0] data, bit last);
    if (!quiet && $urandom_range(99) < 14) begin
      byte_valid <= 1'b0;
      repeat (($urandom_range(15) == 0) ? $urandom_range(4, 15) : $urandom_range(1, 3))
        @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_beat <= '{data_byte: data, last_byte: last};
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
  endtask

  // a packet of the counter pattern; the byte at bad_at is corrupted
  task automatic send_pattern(logic [ByteWidth-1:0] s, logic [ByteWidth-1:0] n, int len,
                              int bad_at);
    logic [ByteWidth-1:0] b;
    for (int i = 0; i < len; i++) begin
      b = n[0] ? s : n;
      if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
      send_byte(b, i == len - 1);
      n = n - 8'd1;
    end
  endtask

  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(bit mode, logic [ByteWidth-1:0] s, logic [ByteWidth-1:0] n);
    cfg_write <= 1'b1;
    cfg_index <= REG_RECOVER_MODE;
    cfg_data <= ByteWidth'(mode);
    @(posedge clk);
    cfg_index <= REG_SEED_VALUE;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= REG_START_COUNT;
    cfg_data <= n;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random_packet(bit mode, logic [ByteWidth-1:0] s, logic [ByteWidth-1:0] n);
    int len;
    int kind;
    int r;
    r = $urandom_range(99);
    if (r < 10) len = $urandom_range(1, 3);
    else if (r < 92) len = $urandom_range(4, 10);
    else len = $urandom_range(20, 48);
    if (mode) begin
      s = 8'($urandom_range(255));
      case ($urandom_range(9))
        0: n = 8'h00;
        1: n = 8'hFF;
        2: n = 8'h03;
        default: n = 8'($urandom_range(255));
      endcase
    end
    kind = $urandom_range(99);
    if (kind < 70) begin
      send_pattern(s, n, len, -1);
    end else if (kind < 85) begin
      send_pattern(s, n, len, $urandom_range(len - 1));
    end else begin
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  initial begin
    logic [ByteWidth-1:0] s;
    logic [ByteWidth-1:0] n;
    bit                   mode;
    int                   target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fixed mode, counter wraps through zero
    set_config(1'b0, 8'hFF, 8'h01);
    send_pattern(8'hFF, 8'h01, 3, -1);
    send_pattern(8'hFF, 8'h01, 1, 0);
    wait_idle();

    // recovery: odd start, even start with wrap, short packet, lost sync,
    // mismatch after a good sync
    set_config(1'b1, 8'h5A, 8'h00);
    send_pattern(8'h3C, 8'h07, 5, -1);
    send_pattern(8'hFF, 8'h00, 5, -1);
    send_pattern(8'h11, 8'h21, 3, -1);
    send_pattern(8'h12, 8'h34, 4, 2);
    send_pattern(8'h80, 8'h7F, 5, 4);

    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      quiet = (phase == 4);
      mode = (phase % 3 != 0);
      s = (phase == 1) ? 8'h00 : (phase == 2) ? 8'hFF : 8'($urandom_range(255));
      n = (phase == 2) ? 8'h00 : (phase == 3) ? 8'hFF : 8'($urandom_range(255));
      set_config(mode, s, n);
      target = bytes_sent + BytesPerPhase;
      while (bytes_sent < target) send_random_packet(mode, s, n);
    end
    quiet = 0;

    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes and %0d verdicts over %0d register settings",
             sb.bytes_seen, sb.verdicts_checked, settings_used);
    $display("fixed and recovery modes, short packets, lost sync, corrupted and noise packets");
    if (sb.errors == 0) begin
      $display("byte_pattern_sync_checker regression: pass");
    end else begin
      $display("byte_pattern_sync_checker regression: fail");
    end
    $finish;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk);
    $display("%0t: timeout after %0d cycles", $time, CycleLimit);
    $display("byte_pattern_sync_checker regression: fail");
    $finish;
  end

endmodule
